### rtl/bptc_pkg.sv
// bptc_pkg: shared types, constants and helpers for the pressure/temperature compensation core
// no dependencies; imported by bptc_ctrl, bptc_dp and the top level
`timescale 1ns / 1ps

package bptc_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;
    localparam int RawW     = 24;
    localparam int PresW    = 32;
    localparam int TempW    = 20;
    localparam int MulW     = 33;
    localparam int ProdW    = 2 * MulW;

    localparam logic [CfgIdxW-1:0] REG_C1      = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_C2      = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_C3      = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_C4      = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_C5      = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_C6      = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_VARIANT = 3'd6;

    localparam logic OP_TEMP = 1'b0;
    localparam logic OP_PRES = 1'b1;

    // floor(x * RECIP10 / 2^35) == floor(x / 10) for x below 2^32
    localparam logic signed [MulW-1:0] RECIP10 = 33'sh0_CCCC_CCCD;

    typedef enum logic [4:0] {
        STEP_NONE,
        STEP_T1, STEP_T2, STEP_T3, STEP_T4, STEP_T5,
        STEP_P1, STEP_P2, STEP_P3, STEP_P4, STEP_P5, STEP_P6,
        STEP_P7, STEP_P8, STEP_P9, STEP_P10, STEP_P11,
        STEP_EMIT
    } step_t;

    typedef struct packed {
        logic  load;
        step_t step;
    } cmd_t;

    typedef struct packed {
        logic filt_valid;
        logic out_space;
    } status_t;

    // signed division by 2^k, truncating toward zero
    function automatic logic signed [ProdW-1:0] sdiv_pow2(input logic signed [ProdW-1:0] x,
                                                          input int unsigned k);
        logic signed [ProdW-1:0] bias;
        bias = x[ProdW-1] ? ((66'sd1 <<< k) - 66'sd1) : '0;
        return (x + bias) >>> k;
    endfunction

endpackage

### rtl/bptc_ctrl.sv
// bptc_ctrl: sequencer for the compensation datapath
// depends on bptc_pkg
`timescale 1ns / 1ps

module bptc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              operation,
    input  bptc_pkg::status_t status,
    output bptc_pkg::cmd_t    cmd
);
    import bptc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T1, S_T2, S_T3, S_T4, S_T5,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_P6,
        S_P7, S_P8, S_P9, S_P10, S_P11,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    step_t  step_reg;
    logic   accept;

    function automatic step_t step_of(input state_t s);
        step_t r;
        unique case (s)
            S_T1:    r = STEP_T1;
            S_T2:    r = STEP_T2;
            S_T3:    r = STEP_T3;
            S_T4:    r = STEP_T4;
            S_T5:    r = STEP_T5;
            S_P1:    r = STEP_P1;
            S_P2:    r = STEP_P2;
            S_P3:    r = STEP_P3;
            S_P4:    r = STEP_P4;
            S_P5:    r = STEP_P5;
            S_P6:    r = STEP_P6;
            S_P7:    r = STEP_P7;
            S_P8:    r = STEP_P8;
            S_P9:    r = STEP_P9;
            S_P10:   r = STEP_P10;
            S_P11:   r = STEP_P11;
            S_OUT:   r = STEP_EMIT;
            default: r = STEP_NONE;
        endcase
        return r;
    endfunction

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign cmd.load = accept;
    assign cmd.step = step_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_TEMP)
                        state_next = S_T1;
                    else if (status.filt_valid)
                        state_next = S_P1;
                end
            end
            S_T1:  state_next = S_T2;
            S_T2:  state_next = S_T3;
            S_T3:  state_next = status.filt_valid ? S_T4 : S_IDLE;
            S_T4:  state_next = S_T5;
            S_T5:  state_next = S_IDLE;
            S_P1:  state_next = S_P2;
            S_P2:  state_next = S_P3;
            S_P3:  state_next = S_P4;
            S_P4:  state_next = S_P5;
            S_P5:  state_next = S_P6;
            S_P6:  state_next = S_P7;
            S_P7:  state_next = S_P8;
            S_P8:  state_next = S_P9;
            S_P9:  state_next = S_P10;
            S_P10: state_next = S_P11;
            S_P11: state_next = S_OUT;
            S_OUT: state_next = status.out_space ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= STEP_NONE;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_of(state_next);
        end
    end

endmodule

### rtl/bptc_dp.sv
// bptc_dp: coefficient registers, shared multiplier, compensation arithmetic and output register
// depends on bptc_pkg; driven by bptc_ctrl
`timescale 1ns / 1ps

module bptc_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bptc_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [bptc_pkg::CfgDataW-1:0]   cfg_data,
    input  logic                            operation,
    input  logic [bptc_pkg::RawW-1:0]       raw_sample,
    input  bptc_pkg::cmd_t                  cmd,
    output bptc_pkg::status_t               status,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [bptc_pkg::PresW-1:0] pressure_pa,
    output logic signed [bptc_pkg::TempW-1:0] temperature_centi
);
    import bptc_pkg::*;

    logic [15:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;
    logic        variant_reg;

    logic [RawW-1:0]          raw_reg;
    logic signed [25:0]       dt_reg;
    logic signed [18:0]       first_reg;
    logic signed [18:0]       filt_reg;
    logic                     fv_reg;
    logic signed [22:0]       num_reg;
    logic                     lo_reg, vlo_reg;
    logic [35:0]              sq_reg, sq2_reg;
    logic [17:0]              t2_reg;
    logic signed [41:0]       off2_reg, sens2_reg, offd_reg, sensd_reg, off_reg, sens_reg;
    logic [47:0]              acc_reg;
    logic signed [43:0]       x_reg;
    logic signed [ProdW-1:0]  p_reg;
    logic signed [PresW-1:0]  res_p_reg, pres_reg;
    logic signed [TempW-1:0]  res_t_reg, temp_reg;
    logic                     out_valid_reg;

    logic signed [MulW-1:0]   mul_a, mul_b;
    logic signed [19:0]       d_val, e_val;
    logic [22:0]              num_mag;
    logic signed [41:0]       base_off, base_sens;
    logic [38:0]              sq5, sq2_7, sq2_11;
    logic signed [ProdW-1:0]  full_prod, y_val, pres_q;
    logic signed [22:0]       q10;
    logic                     out_space;

    assign out_space         = !out_valid_reg || out_ready;
    assign status.filt_valid = fv_reg;
    assign status.out_space  = out_space;
    assign out_valid         = out_valid_reg;
    assign pressure_pa       = pres_reg;
    assign temperature_centi = temp_reg;

    assign d_val   = 20'(filt_reg) - 20'sd2000;
    assign e_val   = 20'(filt_reg) + 20'sd1500;
    assign num_mag = num_reg[22] ? 23'(-num_reg) : 23'(num_reg);

    assign base_off  = variant_reg ? 42'({c2_reg, 16'b0}) : 42'({c2_reg, 17'b0});
    assign base_sens = variant_reg ? 42'({c1_reg, 15'b0}) : 42'({c1_reg, 16'b0});

    assign sq5    = 39'(sq_reg) + 39'({sq_reg, 2'b0});
    assign sq2_7  = 39'({sq2_reg, 3'b0}) - 39'(sq2_reg);
    assign sq2_11 = 39'({sq2_reg, 3'b0}) + 39'({sq2_reg, 1'b0}) + 39'(sq2_reg);

    assign q10       = 23'(p_reg >>> 35);
    assign full_prod = ProdW'($signed({1'b0, acc_reg})) + (p_reg <<< 24);
    assign y_val     = ProdW'(x_reg) - ProdW'(off_reg);
    assign pres_q    = sdiv_pow2(y_val, 15);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.step)
            STEP_T1:
            begin
                mul_a = MulW'(dt_reg);
                mul_b = MulW'($signed({1'b0, c6_reg}));
            end
            STEP_T4:
            begin
                mul_a = MulW'($signed({1'b0, num_mag}));
                mul_b = RECIP10;
            end
            STEP_P1:
            begin
                mul_a = MulW'(d_val);
                mul_b = MulW'(d_val);
            end
            STEP_P2:
            begin
                mul_a = MulW'(e_val);
                mul_b = MulW'(e_val);
            end
            STEP_P3:
            begin
                mul_a = MulW'(dt_reg);
                mul_b = MulW'(dt_reg);
            end
            STEP_P4:
            begin
                mul_a = MulW'(dt_reg);
                mul_b = MulW'($signed({1'b0, c4_reg}));
            end
            STEP_P5:
            begin
                mul_a = MulW'(dt_reg);
                mul_b = MulW'($signed({1'b0, c3_reg}));
            end
            STEP_P8:
            begin
                mul_a = MulW'($signed({1'b0, raw_reg}));
                mul_b = MulW'($signed({1'b0, sens_reg[23:0]}));
            end
            STEP_P9:
            begin
                mul_a = MulW'($signed({1'b0, raw_reg}));
                mul_b = MulW'($signed(sens_reg[41:24]));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg        <= '0;
            c2_reg        <= '0;
            c3_reg        <= '0;
            c4_reg        <= '0;
            c5_reg        <= '0;
            c6_reg        <= '0;
            variant_reg   <= 1'b1;
            dt_reg        <= '0;
            filt_reg      <= '0;
            fv_reg        <= 1'b0;
            t2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_C1:      c1_reg      <= cfg_data;
                    REG_C2:      c2_reg      <= cfg_data;
                    REG_C3:      c3_reg      <= cfg_data;
                    REG_C4:      c4_reg      <= cfg_data;
                    REG_C5:      c5_reg      <= cfg_data;
                    REG_C6:      c6_reg      <= cfg_data;
                    REG_VARIANT: variant_reg <= cfg_data[0];
                    default:     ;
                endcase
            end

            if (cmd.load && operation == OP_TEMP)
                dt_reg <= 26'($signed({2'b0, raw_sample})) - 26'($signed({2'b0, c5_reg, 8'b0}));

            if (cmd.step == STEP_EMIT && out_space)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (cmd.step)
                STEP_T3:
                begin
                    if (!fv_reg)
                    begin
                        filt_reg <= first_reg;
                        fv_reg   <= 1'b1;
                    end
                end
                STEP_T5:
                    filt_reg <= num_reg[22] ? 19'(-q10) : 19'(q10);
                STEP_P4:
                    t2_reg <= lo_reg ? p_reg[48:31] : '0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= mul_a * mul_b;
        if (cmd.load)
            raw_reg <= raw_sample;

        unique case (cmd.step)
            STEP_T2:
                first_reg <= 19'(sdiv_pow2(p_reg, 23) + 66'sd2000);
            STEP_T3:
                num_reg <= 23'($signed({filt_reg, 3'b0})) + 23'(filt_reg) + 23'(first_reg);
            STEP_P1:
            begin
                lo_reg  <= (filt_reg < 19'sd2000);
                vlo_reg <= (filt_reg < -19'sd1500);
            end
            STEP_P2:
                sq_reg <= p_reg[35:0];
            STEP_P3:
                sq2_reg <= p_reg[35:0];
            STEP_P4:
            begin
                if (lo_reg)
                begin
                    off2_reg  <= 42'(sq5 >> 1) + (vlo_reg ? 42'(sq2_7) : 42'd0);
                    sens2_reg <= 42'(sq5 >> 2) + (vlo_reg ? 42'(sq2_11 >> 1) : 42'd0);
                end
                else
                begin
                    off2_reg  <= '0;
                    sens2_reg <= '0;
                end
            end
            STEP_P5:
                offd_reg <= 42'(sdiv_pow2(p_reg, variant_reg ? 7 : 6));
            STEP_P6:
            begin
                off_reg   <= base_off + offd_reg - off2_reg;
                sensd_reg <= 42'(sdiv_pow2(p_reg, variant_reg ? 8 : 7));
            end
            STEP_P7:
                sens_reg <= base_sens + sensd_reg - sens2_reg;
            STEP_P9:
                acc_reg <= p_reg[47:0];
            STEP_P10:
                x_reg <= 44'(sdiv_pow2(full_prod, 21));
            STEP_P11:
            begin
                if (pres_q > 66'sd2147483647)
                    res_p_reg <= 32'sh7FFF_FFFF;
                else if (pres_q < -66'sd2147483648)
                    res_p_reg <= 32'sh8000_0000;
                else
                    res_p_reg <= 32'(pres_q);
                res_t_reg <= 20'(filt_reg) - 20'($signed({2'b0, t2_reg}));
            end
            STEP_EMIT:
            begin
                if (out_space)
                begin
                    pres_reg <= res_p_reg;
                    temp_reg <= res_t_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

### rtl/baro_pressure_temp_compensation_core.sv
// baro_pressure_temp_compensation_core: top level of the second-order compensation core
// depends on bptc_pkg, bptc_ctrl and bptc_dp
//
//   channel   signals                                     direction
//   input     in_valid/in_ready, operation, raw_sample    in
//   output    out_valid/out_ready, pressure_pa,           out
//             temperature_centi
//   config    cfg_we, cfg_index, cfg_data                 in
//
// temperature transaction: steps T1-T3 the first time, T1-T5 after that; pressure
// transaction: P1-P11 then output, the single shared 33x33 multiplier taking every
// product in turn. a pressure transaction before any temperature one yields no result.
// reset clears coefficients, the filter and the output valid flag; variant resets to 1.
// a waiting result holds the sequencer at its final step; inputs are held off meanwhile.
`timescale 1ns / 1ps

module baro_pressure_temp_compensation_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               operation,
    input  logic [bptc_pkg::RawW-1:0]          raw_sample,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [bptc_pkg::PresW-1:0]  pressure_pa,
    output logic signed [bptc_pkg::TempW-1:0]  temperature_centi,
    input  logic                               cfg_we,
    input  logic [bptc_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [bptc_pkg::CfgDataW-1:0]      cfg_data
);
    import bptc_pkg::*;

    cmd_t    cmd;
    status_t status;

    bptc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .status    (status),
        .cmd       (cmd)
    );

    bptc_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .operation         (operation),
        .raw_sample        (raw_sample),
        .cmd               (cmd),
        .status            (status),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .pressure_pa       (pressure_pa),
        .temperature_centi (temperature_centi)
    );

endmodule
